// ===== rtl/qmi_pkg.sv =====
`timescale 1ns / 1ps

package qmi_pkg;

   localparam int CAPACITY       = 1024;
   localparam int VALUE_BITS     = 32;
   localparam int RSP_VALUE_BITS = 32;
   localparam int POS_BITS       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS     = $clog2(CAPACITY + 1);

   // Request codes on req_type; the fourth code is unused and ignored.
   typedef enum logic [1:0] {
      REQ_PUSH_TAIL = 2'd0,
      REQ_PUSH_MID  = 2'd1,
      REQ_POP       = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2
   } cell_op_type;

   // Broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      cell_op_type           op;
      logic [POS_BITS-1:0]   pos;
      logic [VALUE_BITS-1:0] value;
   } cell_cmd_type;

   function automatic logic [RSP_VALUE_BITS-1:0] pop_extend(
      input logic [VALUE_BITS-1:0] v
   );
      logic signed [VALUE_BITS-1:0] sv;
      sv = v;
      return RSP_VALUE_BITS'(sv);
   endfunction

endpackage

// ===== rtl/qmi_cell.sv =====
`timescale 1ns / 1ps

// One queue slot. Shift right past an insert point, shift left on pop.
module qmi_cell (
   input  logic                             clock,
   input  qmi_pkg::cell_cmd_type            cmd,
   input  logic [qmi_pkg::POS_BITS-1:0]     cell_index,
   input  logic [qmi_pkg::VALUE_BITS-1:0]   left_data,
   input  logic [qmi_pkg::VALUE_BITS-1:0]   right_data,
   output logic [qmi_pkg::VALUE_BITS-1:0]   data_out
);

   logic [qmi_pkg::VALUE_BITS-1:0] data_ff;
   logic [qmi_pkg::VALUE_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         qmi_pkg::CELL_INSERT: begin
            if (cell_index == cmd.pos) begin
               data_in = cmd.value;
            end else if (cell_index > cmd.pos) begin
               data_in = left_data;
            end
         end
         qmi_pkg::CELL_POP: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== rtl/qmi_ctrl.sv =====
`timescale 1ns / 1ps

// Request sequencer: hold the request, check it against the fill count,
// drive one command into the cell row and register the result.
module qmi_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_type,
   input  logic signed [31:0]                   req_push_value,
   input  logic [qmi_pkg::VALUE_BITS-1:0]       head_data,
   output qmi_pkg::cell_cmd_type                cmd,
   output logic                                 rsp_strobe,
   output logic signed [31:0]                   rsp_pop_value,
   output logic [1:0]                           rsp_status,
   output logic [10:0]                          rsp_entry_count
);

   logic                               pending_ff;
   logic [1:0]                         code_ff;
   logic [qmi_pkg::VALUE_BITS-1:0]     value_ff;
   logic [qmi_pkg::COUNT_BITS-1:0]     count_ff;
   logic [qmi_pkg::COUNT_BITS-1:0]     count_in;
   logic                               strobe_ff;
   logic [qmi_pkg::RSP_VALUE_BITS-1:0] pop_ff;
   logic [qmi_pkg::RSP_VALUE_BITS-1:0] pop_in;
   qmi_pkg::status_type                status_ff;
   qmi_pkg::status_type                status_in;
   logic                               full;
   logic                               empty;
   logic [qmi_pkg::COUNT_BITS-1:0]     half_up;
   logic                               accept;

   assign accept  = start && !pending_ff;
   assign full    = (count_ff == qmi_pkg::COUNT_BITS'(qmi_pkg::CAPACITY));
   assign empty   = (count_ff == '0);
   assign half_up = (count_ff + qmi_pkg::COUNT_BITS'(1)) >> 1;

   always_comb begin
      cmd.op    = qmi_pkg::CELL_HOLD;
      cmd.pos   = count_ff[qmi_pkg::POS_BITS-1:0];
      cmd.value = value_ff;
      count_in  = count_ff;
      pop_in    = '0;
      status_in = qmi_pkg::STATUS_OK;
      if (pending_ff) begin
         case (code_ff)
            qmi_pkg::REQ_PUSH_TAIL: begin
               if (full) begin
                  status_in = qmi_pkg::STATUS_FULL;
               end else begin
                  cmd.op   = qmi_pkg::CELL_INSERT;
                  count_in = count_ff + qmi_pkg::COUNT_BITS'(1);
               end
            end
            qmi_pkg::REQ_PUSH_MID: begin
               if (full) begin
                  status_in = qmi_pkg::STATUS_FULL;
               end else begin
                  cmd.op   = qmi_pkg::CELL_INSERT;
                  cmd.pos  = half_up[qmi_pkg::POS_BITS-1:0];
                  count_in = count_ff + qmi_pkg::COUNT_BITS'(1);
               end
            end
            qmi_pkg::REQ_POP: begin
               if (empty) begin
                  status_in = qmi_pkg::STATUS_EMPTY;
               end else begin
                  cmd.op   = qmi_pkg::CELL_POP;
                  pop_in   = qmi_pkg::pop_extend(head_data);
                  count_in = count_ff - qmi_pkg::COUNT_BITS'(1);
               end
            end
            default: begin
               cmd.op = qmi_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
         strobe_ff  <= 1'b0;
         status_ff  <= qmi_pkg::STATUS_OK;
      end else begin
         pending_ff <= accept;
         count_ff   <= count_in;
         strobe_ff  <= pending_ff;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff  <= req_type;
         value_ff <= qmi_pkg::VALUE_BITS'(req_push_value);
      end
      pop_ff <= pop_in;
   end

   assign busy            = pending_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_pop_value   = pop_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = 11'(count_ff);

endmodule

// ===== rtl/queue_with_middle_insert.sv =====
// Ordered queue of signed 32-bit values, 1024 entries, with push at the
// tail, push into the middle (0-based position ceil(n/2)) and pop from head.
// Request channel: drive req_type and req_push_value with start; a transfer
// happens at a rising edge with start high and busy low. busy is high in
// the cycle after each transfer.
// Result channel: every request gives exactly one result. rsp_strobe is
// high for one cycle with rsp_pop_value, rsp_status and rsp_entry_count;
// the receiver cannot stall it. A pop on an empty queue and a push on a
// full queue change nothing and report their status.
// A transfer is captured into the sequencer's pending register; the
// request is then applied to the cell row and its result registered.
// No new request is taken while busy, that is while one is pending.
// Storage is a row of identical cells, one entry each; on every applied
// request each cell holds, loads the value, or takes its neighbor's entry.
// Reset (synchronous, active high) empties the queue at once; entry data
// past the fill count is never read.
`timescale 1ns / 1ps

module queue_with_middle_insert (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic signed [31:0]  req_push_value,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_pop_value,
   output logic [1:0]          rsp_status,
   output logic [10:0]         rsp_entry_count
);

   qmi_pkg::cell_cmd_type          cmd;
   logic [qmi_pkg::VALUE_BITS-1:0] cell_data [qmi_pkg::CAPACITY];

   // Sequencer: count, request decode and result register.
   qmi_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .head_data       (cell_data[0]),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Cell row: cell 0 is the head. Left neighbor feeds an insert shift,
   // right neighbor feeds a pop shift; the ends see zero.
   for (genvar i = 0; i < qmi_pkg::CAPACITY; i++) begin : g_cell
      logic [qmi_pkg::VALUE_BITS-1:0] left_data;
      logic [qmi_pkg::VALUE_BITS-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == qmi_pkg::CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      qmi_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (qmi_pkg::POS_BITS'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i])
      );
   end

endmodule

// ===== rtl/qmi_checker.sv =====
`timescale 1ns / 1ps

module qmi_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_pop_value,
   input logic [1:0]         rsp_status,
   input logic [10:0]        rsp_entry_count
);

   logic xfer;
   assign xfer = start && !busy;

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      xfer |=> busy)
      else $error("busy not raised after a transfer");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##2 rsp_strobe)
      else $error("no result two cycles after a transfer");

   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result shown while a request is in flight");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == 2'(qmi_pkg::STATUS_EMPTY))
         |-> (rsp_entry_count == 11'd0 && rsp_pop_value == 32'sd0))
      else $error("empty status with entries or a value");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == 2'(qmi_pkg::STATUS_FULL))
         |-> (rsp_entry_count == 11'(qmi_pkg::CAPACITY)))
      else $error("full status below capacity");

endmodule

bind queue_with_middle_insert qmi_checker u_checker (.*);

// ===== verif/tb_queue_with_middle_insert.sv =====
`timescale 1ns / 1ps

module tb_queue_with_middle_insert;

   // The fourth request code has no enum member; the block must ignore it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 2;
   localparam int RANDOM_ITEMS  = 380;
   localparam int IDLE_PERCENT  = 36;
   localparam int SETTLE_CYCLES = 4;
   // Cycles without any transfer before the run is declared hung.
   localparam int STALL_LIMIT   = 5000;

   typedef struct packed {
      logic [31:0]         pop_value;
      qmi_pkg::status_type status;
      logic [10:0]         entry_count;
   } response_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [1:0]         req_type       = qmi_pkg::REQ_PUSH_TAIL;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_pop_value;
   logic [1:0]         rsp_status;
   logic [10:0]        rsp_entry_count;

   // Queue contents in order, head at index 0. VALUE_BITS matches the
   // 32-bit result field, so no extension is needed on a pop.
   logic [31:0]  stored_values[$];
   response_type expected_responses[$];

   int error_count  = 0;
   int stall_cycles = 0;
   bit idle_enable  = 1'b1;

   queue_with_middle_insert dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Apply one request to the ordered queue and return the response it
   // must produce. A middle push lands at position ceil(n/2), which for an
   // empty queue is simply the tail.
   function automatic response_type next_queue_response(input logic [1:0]  code,
                                                        input logic [31:0] value);
      response_type rsp;
      int           depth;
      depth         = stored_values.size();
      rsp.pop_value = '0;
      rsp.status    = qmi_pkg::STATUS_OK;
      case (code)
         qmi_pkg::REQ_PUSH_TAIL, qmi_pkg::REQ_PUSH_MID: begin
            if (depth >= qmi_pkg::CAPACITY) begin
               // drop the value, keep the queue as it is
               rsp.status = qmi_pkg::STATUS_FULL;
            end else if (code == qmi_pkg::REQ_PUSH_TAIL) begin
               stored_values.push_back(value);
            end else begin
               stored_values.insert((depth + 1) / 2, value);
            end
         end
         qmi_pkg::REQ_POP: begin
            if (depth == 0) begin
               rsp.status = qmi_pkg::STATUS_EMPTY;
            end else begin
               rsp.pop_value = stored_values.pop_front();
            end
         end
         default: begin
            // unused code: no change, plain ok status
         end
      endcase
      rsp.entry_count = 11'(stored_values.size());
      return rsp;
   endfunction

   // Pick a request code by percentage; whatever is left over goes to the
   // unused code.
   function automatic logic [1:0] pick_request(input int tail_pct,
                                               input int mid_pct,
                                               input int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < tail_pct) return qmi_pkg::REQ_PUSH_TAIL;
      if (roll < tail_pct + mid_pct) return qmi_pkg::REQ_PUSH_MID;
      if (roll < tail_pct + mid_pct + pop_pct) return qmi_pkg::REQ_POP;
      return REQ_UNUSED;
   endfunction

   // Uniform values half the time, the four corner patterns the other half.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Drive one request and hold it until the block takes it. start stays
   // high on return so a back-to-back request keeps it up without a glitch;
   // any caller that waits on something else lowers it first.
   task automatic send_request(input logic [1:0] code, input logic [31:0] value);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= code;
      req_push_value <= value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      // The transfer has happened: record what it must return.
      expected_responses.push_back(next_queue_response(code, value));
   endtask

   // Lower start and hold off until every outstanding response has arrived.
   task automatic wait_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   // Empty-queue cases, middle push into an empty queue, the value corners,
   // the unused code, then pops down to empty and one past it.
   task automatic test_directed();
      send_request(qmi_pkg::REQ_POP, 32'h1234_5678);
      send_request(REQ_UNUSED, 32'hffff_ffff);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'h8000_0000);
      send_request(qmi_pkg::REQ_PUSH_TAIL, 32'h7fff_ffff);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'h0000_0000);
      send_request(qmi_pkg::REQ_PUSH_TAIL, 32'hffff_ffff);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'h5555_5555);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'haaaa_aaaa);
      send_request(REQ_UNUSED, 32'h0000_0001);
      send_request(qmi_pkg::REQ_PUSH_TAIL, 32'h0000_0001);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'hfffe_0001);
      // pop values are ignored: drive junk to prove it
      repeat (9) send_request(qmi_pkg::REQ_POP, $urandom);
      send_request(qmi_pkg::REQ_PUSH_MID, 32'h0000_0002);
      send_request(qmi_pkg::REQ_POP, 32'hffff_ffff);
   endtask

   // Mixed traffic at moderate depth, with one stretch of requests sent without
   // idle gaps and one pause until the pipeline is empty.
   task automatic test_random_mix();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_enable = !(i >= 150 && i < 300);
         if (i == 330) wait_until_drained();
         send_request(pick_request(35, 30, 30), pick_value());
      end
      idle_enable = 1'b1;
   endtask

   // Pop-heavy traffic back down to empty, then the empty boundary.
   task automatic test_drain_to_empty();
      while (stored_values.size() > 0) begin
         send_request(pick_request(10, 10, 75), pick_value());
      end
      repeat (3) send_request(qmi_pkg::REQ_POP, pick_value());
      send_request(qmi_pkg::REQ_PUSH_MID, pick_value());
      send_request(qmi_pkg::REQ_POP, pick_value());
      send_request(qmi_pkg::REQ_POP, pick_value());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_drain_to_empty();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[queue_with_middle_insert] OK");
      end else begin
         $display("[queue_with_middle_insert] ERROR");
      end
      $finish;
   end

   // Compare every strobed response with the oldest outstanding one.
   always @(posedge clock) begin : check_response
      response_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h/%0d/%0d",
                     $time, rsp_pop_value, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_pop_value !== want.pop_value) begin
               $display("%0t: pop_value expected %h actual %h",
                        $time, want.pop_value, rsp_pop_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Restart the count on any transfer in either direction.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("[queue_with_middle_insert] ERROR");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
rtl/qmi_pkg.sv
rtl/qmi_cell.sv
rtl/qmi_ctrl.sv
rtl/queue_with_middle_insert.sv
rtl/qmi_checker.sv
verif/tb_queue_with_middle_insert.sv
